>>> src/ietc_pkg.sv
// Package with the constants and record type of the infrared edge timing capture block.
package ietc_pkg;

  localparam int unsigned MAX_EDGES = 128;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_W = 16;
  localparam logic [CFG_W-1:0] SILENCE_RESET = 16'd10000;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  localparam logic [COUNT_W-1:0] MAX_EDGES_C = COUNT_W'(MAX_EDGES);

  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_FRAME_END = 1'b1
  } rec_kind_t;

  typedef struct packed {
    logic [COUNT_W-1:0] edge_count;
    logic new_level;
    logic [TICK_W-1:0] duration_ticks;
    rec_kind_t record_kind;
  } rec_t;

endpackage

>>> src/ir_edge_timing_capture.sv
// Top level of the infrared edge timing capture block.
// The block takes one line sample per clock on the input stream and can take
// a new sample in each cycle that in_tready is high. Results leave through a
// two-entry output stage (output register plus skid register), so in_tready
// drops only when both entries hold records that the sink has not taken. A
// record is registered in the output or, if that is held, the skid register.
// The always-ready cfg channel writes the silence timeout register.
module ir_edge_timing_capture (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,     // silence_timeout
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [0] line_level, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [15:0] duration_ticks, [16] new_level,
                                    // [24:17] edge_count, [31:25] zero
  output logic [0:0]  out_tuser     // [0] record_kind
);
  import ietc_pkg::*;

  logic [CFG_W-1:0]   silence_r;
  logic               prev_level_r, prev_level_nxt;
  logic [TICK_W-1:0]  ticks_r, ticks_nxt;
  logic               in_frame_r, in_frame_nxt;
  logic [COUNT_W-1:0] edges_r, edges_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  rec_t               out_rec_r, out_rec_nxt;
  rec_t               skid_rec_r, skid_rec_nxt;

  logic               level;
  logic               accept;
  logic               is_edge;
  logic [TICK_W-1:0]  elapsed;
  logic               res_valid;
  rec_t               res;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign accept = in_tvalid && in_tready;
  assign level = in_tdata[0];
  assign elapsed = (ticks_r == TICK_MAX) ? TICK_MAX : ticks_r + TICK_W'(1);
  assign is_edge = (level != prev_level_r);

  always_comb begin
    prev_level_nxt = prev_level_r;
    ticks_nxt = ticks_r;
    in_frame_nxt = in_frame_r;
    edges_nxt = edges_r;
    res_valid = 1'b0;
    res = '0;
    if (accept) begin
      ticks_nxt = elapsed;
      if (is_edge) begin
        prev_level_nxt = level;
        ticks_nxt = '0;
        if (!in_frame_r) begin
          if (!level && (elapsed >= silence_r)) begin
            in_frame_nxt = 1'b1;
            edges_nxt = '0;
          end
        end else if (edges_r < MAX_EDGES_C) begin
          edges_nxt = edges_r + COUNT_W'(1);
          res_valid = 1'b1;
          res.record_kind = KIND_EDGE;
          res.duration_ticks = elapsed;
          res.new_level = level;
        end
      end else if (in_frame_r && (elapsed >= silence_r)) begin
        in_frame_nxt = 1'b0;
        edges_nxt = '0;
        if (edges_r != '0) begin
          res_valid = 1'b1;
          res.record_kind = KIND_FRAME_END;
          res.edge_count = edges_r;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rec_nxt = out_rec_r;
    skid_valid_nxt = skid_valid_r;
    skid_rec_nxt = skid_rec_r;
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt = 1'b1;
        out_rec_nxt = skid_rec_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_rec_nxt = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_rec_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_r <= SILENCE_RESET;
      prev_level_r <= 1'b1;
      ticks_r <= '0;
      in_frame_r <= 1'b0;
      edges_r <= '0;
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        silence_r <= cfg_data;
      end
      prev_level_r <= prev_level_nxt;
      ticks_r <= ticks_nxt;
      in_frame_r <= in_frame_nxt;
      edges_r <= edges_nxt;
      out_valid_r <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r <= out_rec_nxt;
    skid_rec_r <= skid_rec_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {7'd0, out_rec_r.edge_count, out_rec_r.new_level,
                      out_rec_r.duration_ticks};
  assign out_tuser = out_rec_r.record_kind;

`ifndef SYNTHESIS
  a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edges_r <= MAX_EDGES_C)
    else $error("Edge count exceeds its maximum.");

  a_idle_no_edges: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> edges_r == '0)
    else $error("Edge count is nonzero while idle.");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("Skid entry holds a record while the output register is empty.");

  a_frame_end_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rec_r.record_kind == KIND_FRAME_END)
      |-> (out_rec_r.edge_count != '0 && out_rec_r.duration_ticks == '0))
    else $error("Frame end record carries a bad payload.");

  a_edge_record: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rec_r.record_kind == KIND_EDGE)
      |-> (out_rec_r.edge_count == '0 && out_rec_r.duration_ticks != '0))
    else $error("Edge record carries a bad payload.");
`endif

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the infrared edge timing capture block.
`timescale 1ns / 100ps

module testbench;
  import ietc_pkg::*;

  typedef struct {
    logic level;
    bit   drain_first;
  } line_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [0] line_level, [7:1] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [15:0] duration_ticks, [16] new_level, [24:17] edge_count
  logic [0:0]  out_tuser;         // [0] record_kind

  line_item_t line_samples[$];
  rec_t       expected_records[$];
  line_item_t cur_sample;
  rec_t       want;
  int         queued_total = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         fail_count = 0;
  bit         idling_on = 1'b1;

  // Mirror of the block's state, advanced once per accepted line sample.
  logic [CFG_W-1:0]   silence_cfg = SILENCE_RESET;
  logic               last_level = 1'b1;
  logic [TICK_W-1:0]  tick_count = '0;
  bit                 framing = 1'b0;
  logic [COUNT_W-1:0] edges_in_frame = '0;

  ir_edge_timing_capture i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void track_sample(input logic lvl);
    logic [TICK_W-1:0] elapsed;
    rec_t rec;
    if (tick_count != TICK_MAX) tick_count++;
    elapsed = tick_count;
    rec = '0;
    if (lvl != last_level) begin
      last_level = lvl;
      tick_count = '0;
      if (!framing) begin
        if (lvl == 1'b0 && elapsed >= silence_cfg) begin
          framing = 1'b1;
          edges_in_frame = '0;
        end
      end else if (edges_in_frame < MAX_EDGES_C) begin
        edges_in_frame++;
        rec.record_kind = KIND_EDGE;
        rec.duration_ticks = elapsed;
        rec.new_level = lvl;
        expected_records.push_back(rec);
      end
    end else if (framing && elapsed >= silence_cfg) begin
      framing = 1'b0;
      if (edges_in_frame != 0) begin
        rec.record_kind = KIND_FRAME_END;
        rec.edge_count = edges_in_frame;
        expected_records.push_back(rec);
      end
      edges_in_frame = '0;
    end
  endfunction

  function automatic void note_failure(input string what, input longint exp_v,
                                       input longint act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch in %s: expected %0d, got %0d", what, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) track_sample(in_tdata[0]);
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (line_samples.size() != 0 &&
                     !(line_samples[0].drain_first && expected_records.size() != 0)) begin
          cur_sample = line_samples.pop_front();
          in_tdata <= {7'd0, cur_sample.level};
          in_tvalid <= 1'b1;
          if (idling_on && $urandom_range(0, 11) == 0) gap_left = $urandom_range(1, 6);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_records.size() == 0) begin
          note_failure("unexpected record, tdata", 0, out_tdata);
        end else begin
          want = expected_records.pop_front();
          if (out_tuser[0] !== want.record_kind)
            note_failure("record_kind", want.record_kind, out_tuser[0]);
          if (out_tdata[15:0] !== want.duration_ticks)
            note_failure("duration_ticks", want.duration_ticks, out_tdata[15:0]);
          if (out_tdata[16] !== want.new_level)
            note_failure("new_level", want.new_level, out_tdata[16]);
          if (out_tdata[24:17] !== want.edge_count)
            note_failure("edge_count", want.edge_count, out_tdata[24:17]);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idling_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 6);
      end
    end
  end

  task automatic push_sample(input logic lvl, input bit drain);
    line_item_t item;
    item.level = lvl;
    item.drain_first = drain;
    line_samples.push_back(item);
    queued_total++;
  endtask

  task automatic push_run(input logic lvl, input int n);
    repeat (n) push_sample(lvl, 1'b0);
  endtask

  // Silence near the threshold, a start edge, a train of pulses, closing silence.
  task automatic push_random_frame(input int t, input int n_edges, input int max_pulse);
    int   quiet;
    logic lvl;
    quiet = t + $urandom_range(0, 4) - 2;
    if (quiet < 1) quiet = 1;
    push_sample(1'b1, $urandom_range(0, 15) == 0);
    push_run(1'b1, quiet - 1);
    lvl = 1'b0;
    push_run(lvl, $urandom_range(1, max_pulse));
    repeat (n_edges) begin
      lvl = ~lvl;
      push_run(lvl, $urandom_range(1, max_pulse));
    end
    push_run(1'b1, t + $urandom_range(0, 3));
  endtask

  task automatic write_timeout(input logic [15:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    silence_cfg = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_idle();
    @(posedge clk);
    while (line_samples.size() != 0 || in_tvalid || expected_records.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int t;
    int start_count;
    int max_pulse;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timeout: short silences never start a frame, so no records come.
    push_run(1'b1, 20);
    push_run(1'b0, 3);
    push_run(1'b1, 5);
    push_run(1'b0, 2);
    push_run(1'b1, 4);
    wait_for_idle();

    // Timeout of one: single-tick pulses keep the frame, the first repeat ends it.
    write_timeout(16'd1);
    push_run(1'b1, 2);
    push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b0);
    push_sample(1'b0, 1'b0);
    push_run(1'b1, 3);
    wait_for_idle();

    // Timeout of zero: an empty frame, then a frame with two level changes.
    write_timeout(16'd0);
    push_run(1'b0, 2);
    push_sample(1'b1, 1'b0);
    push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b0);
    push_run(1'b0, 3);
    push_run(1'b1, 2);
    wait_for_idle();

    // A frame longer than the edge limit.
    write_timeout(16'd16);
    push_run(1'b1, 20);
    push_random_frame(16, 135, 2);
    wait_for_idle();

    for (int p = 0; p < 6; p++) begin
      if (p == 5) idling_on = 1'b0;
      t = (p % 2 == 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      write_timeout(t[15:0]);
      start_count = queued_total;
      while (queued_total - start_count < 90) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(3, 20)) push_sample(1'($urandom_range(0, 1)), 1'b0);
        end else begin
          max_pulse = ($urandom_range(0, 4) == 0) ? t + 3 : t;
          push_random_frame(t, $urandom_range(0, 12), max_pulse);
        end
      end
      wait_for_idle();
    end
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ir_edge_timing_capture] OK");
    end else begin
      $display("[ir_edge_timing_capture] ERROR");
    end
    $finish;
  end

  initial begin
    #(1_000_000);
    $display("[ir_edge_timing_capture] ERROR");
    $finish;
  end

endmodule
